/* rtl/core/pqsbt_pkg.sv */
package pqsbt_pkg;

  localparam int MsgW  = 32;
  localparam int ChanW = 4;

  typedef logic [MsgW-1:0]  word_t;
  typedef logic [ChanW-1:0] chan_t;

  // Queue identifiers; also the target class code on the output
  typedef enum logic [1:0] {
    Q_DOWN  = 2'd0,
    Q_NETID = 2'd1,
    Q_BCAST = 2'd2,
    Q_NONE  = 2'd3
  } queue_id_t;

  // Operation codes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_ENQUEUE = 1'b1;

  // Enqueue status codes
  localparam logic ENQ_OK      = 1'b0;
  localparam logic ENQ_DROPPED = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [1:0] queue_select;
    word_t      message;
    chan_t      source_channel;
  } in_item_t;

  typedef struct packed {
    logic       drive_valid;
    logic       bit_value;
    logic [1:0] target_class;
    chan_t      exclude_channel;
    logic       frame_last;
    logic       enqueue_status;
  } out_item_t;

  // Occupancy flags of one queue
  typedef struct packed {
    logic empty;
    logic full;
    logic multi;  // two or more words held
  } qstat_t;

endpackage

/* rtl/core/pqsbt_stream_if.sv */
interface pqsbt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/pqsbt_cell.sv */
module pqsbt_cell (
  input  logic              clk,
  input  logic              load,
  input  logic              shift,
  input  pqsbt_pkg::word_t  load_word,
  input  pqsbt_pkg::word_t  next_word,
  output pqsbt_pkg::word_t  word
);
  import pqsbt_pkg::*;

  word_t data;

  // Shift toward the head on pop, otherwise capture a pushed word
  always_ff @(posedge clk) begin
    if (shift) begin
      data <= next_word;
    end else if (load) begin
      data <= load_word;
    end
  end

  assign word = data;

endmodule

/* rtl/core/pqsbt_queue.sv */
module pqsbt_queue #(
  parameter int DEPTH = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              pop,
  input  pqsbt_pkg::word_t  push_word,
  output pqsbt_pkg::word_t  head,
  output pqsbt_pkg::word_t  second,
  output pqsbt_pkg::qstat_t stat
);
  import pqsbt_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  word_t           words [DEPTH];
  word_t           nb    [DEPTH];

  // Row of entry cells, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i < DEPTH - 1) begin : g_mid
      assign nb[i] = words[i+1];
    end else begin : g_end
      assign nb[i] = words[i];
    end

    pqsbt_cell u_cell (
      .clk       (clk),
      .load      (push && !stat.full && (count == CntW'(i))),
      .shift     (pop && !stat.empty),
      .load_word (push_word),
      .next_word (nb[i]),
      .word      (words[i])
    );
  end

  if (DEPTH > 1) begin : g_second
    assign second = words[1];
  end else begin : g_second_one
    assign second = words[0];
  end

  assign head = words[0];

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CntW'(DEPTH));
  assign stat.multi = (count > CntW'(1));

  // Fill count
  always_comb begin
    count_next = count;
    if (push && !stat.full) begin
      count_next = count + CntW'(1);
    end else if (pop && !stat.empty) begin
      count_next = count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

/* rtl/core/priority_queued_serial_bit_transmitter.sv */
// Priority-queued serial bit transmitter.
// Input channel "item" carries one transaction per cycle: either an enqueue
// of a 32-bit message into the downstream, network-id or broadcast queue,
// or one bit-time tick. Output channel "result" returns exactly one
// transaction for each accepted input, in order.
// Each queue is a row of entry cells that shift toward the head on pop.
// An idle sender picks the first non-empty queue (downstream, network-id,
// broadcast) on a tick and drives nothing that tick; the next FRAME_TICKS
// ticks each drive one bit, MSB first, zeros after the message word. The
// tick after the last bit pops the queue and picks again in the same tick.
// The result is registered and appears in the cycle after the input is accepted.
// Throughput: one transaction per cycle; the output register is refilled in
// the cycle it is taken, so input stalls only while a result waits and the
// receiver holds ready low.
// Reset (synchronous, rst high) empties all queues and idles the sender;
// queue storage itself is not cleared and is never read before written.
module priority_queued_serial_bit_transmitter #(
  parameter int DOWNSTREAM_DEPTH = 3,
  parameter int NETID_DEPTH      = 5,
  parameter int BROADCAST_DEPTH  = 3,
  parameter int FRAME_TICKS      = 33
) (
  input logic           clk,
  input logic           rst,
  pqsbt_stream_if.sink   item,
  pqsbt_stream_if.source result
);
  import pqsbt_pkg::*;

  localparam int BitCntW = $clog2(FRAME_TICKS + 1);

  in_item_t            req;
  out_item_t           rsp;
  out_item_t           rsp_q;
  logic                rsp_valid;
  logic                accept;

  queue_id_t           cur;
  queue_id_t           cur_next;
  queue_id_t           cur_eff;
  logic [BitCntW-1:0]  bit_cnt;
  logic [BitCntW-1:0]  bit_cnt_next;
  logic [BitCntW-1:0]  bit_cnt_inc;
  word_t               head_shift;
  word_t               head_shift_next;
  chan_t               excl;
  chan_t               excl_next;
  logic                finishing;

  logic                push_ds, push_ni, push_bc;
  logic                pop_ds, pop_ni, pop_bc;
  word_t               head_ds, head_ni, head_bc;
  word_t               sec_ds, sec_ni, sec_bc;
  qstat_t              st_ds, st_ni, st_bc;
  logic                avail_ds, avail_ni, avail_bc;
  word_t               pick_ds, pick_ni, pick_bc;

  // Queues
  pqsbt_queue #(.DEPTH(DOWNSTREAM_DEPTH)) u_ds (
    .clk(clk), .rst(rst), .push(push_ds), .pop(pop_ds), .push_word(req.message),
    .head(head_ds), .second(sec_ds), .stat(st_ds)
  );

  pqsbt_queue #(.DEPTH(NETID_DEPTH)) u_ni (
    .clk(clk), .rst(rst), .push(push_ni), .pop(pop_ni), .push_word(req.message),
    .head(head_ni), .second(sec_ni), .stat(st_ni)
  );

  pqsbt_queue #(.DEPTH(BROADCAST_DEPTH)) u_bc (
    .clk(clk), .rst(rst), .push(push_bc), .pop(pop_bc), .push_word(req.message),
    .head(head_bc), .second(sec_bc), .stat(st_bc)
  );

  // Handshake
  assign req        = item.payload;
  assign item.ready = !rsp_valid || result.ready;
  assign accept     = item.valid && item.ready;

  // End of frame: pop and pick again on this tick
  assign finishing   = (cur != Q_NONE) && (bit_cnt >= BitCntW'(FRAME_TICKS));
  assign cur_eff     = finishing ? Q_NONE : cur;
  assign bit_cnt_inc = bit_cnt + BitCntW'(1);

  // Occupancy and head word as seen after a pop in this same tick
  assign avail_ds = (finishing && cur == Q_DOWN)  ? st_ds.multi : !st_ds.empty;
  assign avail_ni = (finishing && cur == Q_NETID) ? st_ni.multi : !st_ni.empty;
  assign avail_bc = (finishing && cur == Q_BCAST) ? st_bc.multi : !st_bc.empty;
  assign pick_ds  = (finishing && cur == Q_DOWN)  ? sec_ds : head_ds;
  assign pick_ni  = (finishing && cur == Q_NETID) ? sec_ni : head_ni;
  assign pick_bc  = (finishing && cur == Q_BCAST) ? sec_bc : head_bc;

  // Per-transaction step
  always_comb begin
    push_ds         = 1'b0;
    push_ni         = 1'b0;
    push_bc         = 1'b0;
    pop_ds          = 1'b0;
    pop_ni          = 1'b0;
    pop_bc          = 1'b0;
    rsp             = '0;
    cur_next        = cur;
    bit_cnt_next    = bit_cnt;
    head_shift_next = head_shift;
    excl_next       = excl;
    if (accept) begin
      if (req.operation == OP_ENQUEUE) begin
        case (queue_id_t'(req.queue_select))
          Q_DOWN: begin
            if (st_ds.full) rsp.enqueue_status = ENQ_DROPPED;
            else push_ds = 1'b1;
          end
          Q_NETID: begin
            if (st_ni.full) rsp.enqueue_status = ENQ_DROPPED;
            else push_ni = 1'b1;
          end
          Q_BCAST: begin
            if (st_bc.full) begin
              rsp.enqueue_status = ENQ_DROPPED;
            end else begin
              push_bc   = 1'b1;
              excl_next = req.source_channel;
            end
          end
          default: rsp.enqueue_status = ENQ_DROPPED;
        endcase
      end else begin
        pop_ds = finishing && (cur == Q_DOWN);
        pop_ni = finishing && (cur == Q_NETID);
        pop_bc = finishing && (cur == Q_BCAST);
        if (cur_eff == Q_NONE) begin
          // Selection tick, nothing driven
          bit_cnt_next = '0;
          if (avail_ds) begin
            cur_next        = Q_DOWN;
            head_shift_next = pick_ds;
          end else if (avail_ni) begin
            cur_next        = Q_NETID;
            head_shift_next = pick_ni;
          end else if (avail_bc) begin
            cur_next        = Q_BCAST;
            head_shift_next = pick_bc;
          end else begin
            cur_next = Q_NONE;
          end
        end else begin
          // Drive one bit, MSB first
          bit_cnt_next        = bit_cnt_inc;
          head_shift_next     = {head_shift[MsgW-2:0], 1'b0};
          rsp.drive_valid     = 1'b1;
          rsp.bit_value       = head_shift[MsgW-1];
          rsp.target_class    = cur;
          rsp.exclude_channel = (cur == Q_BCAST) ? excl : '0;
          rsp.frame_last      = (bit_cnt_inc == BitCntW'(FRAME_TICKS));
        end
      end
    end
  end

  // Sender state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur        <= Q_NONE;
      bit_cnt    <= '0;
      head_shift <= '0;
      excl       <= '0;
    end else begin
      cur        <= cur_next;
      bit_cnt    <= bit_cnt_next;
      head_shift <= head_shift_next;
      excl       <= excl_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (result.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_q <= rsp;
    end
  end

  assign result.valid   = rsp_valid;
  assign result.payload = rsp_q;

endmodule
